// File: design/sorted_list_merge_top_assert.svh
// assertion macros for the sorted list merge block
// expects i_clk and i_rst_n in the scope of each use
`ifndef SORTED_LIST_MERGE_TOP_ASSERT_SVH
`define SORTED_LIST_MERGE_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SLM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/slm_pkg.sv
// shared constants and types for the sorted list merge block
// no dependencies
package slm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_A = 2'd0,
        CMD_PUSH_B = 2'd1,
        CMD_MERGE  = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

endpackage

// File: design/sorted_list_merge_top.sv
// merge of two ascending signed lists held in two ram stores
// push: one item per cycle, no result. merge: the taken merge item moves the state to
// merge, from which results are registered one per cycle while i_out_stall is low;
// n stored elements give n results, input stalled for the whole run.
// the head of each list comes straight from its ram read register.
// reset clears counts, drop flag, state and output valid; stores need no clearing
`include "sorted_list_merge_top_assert.svh"

module sorted_list_merge_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_command,
    input  logic signed [31:0]          i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_merged_value,
    output logic                        o_from_list_b,
    output logic                        o_last,
    output logic                        o_dropped
);
    import slm_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]   r_ia, n_ia, r_ib, n_ib;
    logic               r_overflow, n_overflow;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_merged_value, n_merged_value;
    logic               r_from_b, n_from_b;
    logic               r_last, n_last;
    logic               r_dropped, n_dropped;

    logic               w_accept;
    logic               w_we_a, w_we_b;
    logic [DATA_W-1:0]  w_rdata_a, w_rdata_b;
    logic               w_a_left, w_b_left, w_take_b, w_is_last, w_slot_free;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    // list stores
    slm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(DATA_W)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_ia[IDX_W-1:0]),
        .o_rdata (w_rdata_a)
    );

    slm_ram #(.DEPTH(LIST_DEPTH), .WIDTH(DATA_W)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_ib[IDX_W-1:0]),
        .o_rdata (w_rdata_b)
    );

    // head selection, b wins a tie
    always_comb begin
        w_a_left = (r_ia != r_cnt_a);
        w_b_left = (r_ib != r_cnt_b);
        w_take_b = !w_a_left ||
                   (w_b_left && !($signed(w_rdata_a) < $signed(w_rdata_b)));
        if (w_take_b) begin
            w_is_last = !w_a_left && ((r_ib + CNT_W'(1)) == r_cnt_b);
        end else begin
            w_is_last = !w_b_left && ((r_ia + CNT_W'(1)) == r_cnt_a);
        end
        w_slot_free = !r_out_valid || !i_out_stall;
    end

    // next state, store writes and result register
    always_comb begin
        n_state        = r_state;
        n_cnt_a        = r_cnt_a;
        n_cnt_b        = r_cnt_b;
        n_ia           = r_ia;
        n_ib           = r_ib;
        n_overflow     = r_overflow;
        n_out_valid    = r_out_valid && i_out_stall;
        n_merged_value = r_merged_value;
        n_from_b       = r_from_b;
        n_last         = r_last;
        n_dropped      = r_dropped;
        w_we_a         = 1'b0;
        w_we_b         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_ia = '0;
                n_ib = '0;
                if (w_accept) begin
                    case (i_command)
                        CMD_PUSH_A: begin
                            if (r_cnt_a != CNT_W'(LIST_DEPTH)) begin
                                w_we_a  = 1'b1;
                                n_cnt_a = r_cnt_a + CNT_W'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        CMD_PUSH_B: begin
                            if (r_cnt_b != CNT_W'(LIST_DEPTH)) begin
                                w_we_b  = 1'b1;
                                n_cnt_b = r_cnt_b + CNT_W'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        CMD_MERGE: begin
                            if (r_cnt_a == '0 && r_cnt_b == '0) begin
                                n_overflow = 1'b0;
                            end else begin
                                n_state = ST_MERGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                if (w_slot_free) begin
                    n_out_valid    = 1'b1;
                    n_merged_value = w_take_b ? w_rdata_b : w_rdata_a;
                    n_from_b       = w_take_b;
                    n_last         = w_is_last;
                    n_dropped      = r_overflow;
                    if (w_take_b) begin
                        n_ib = r_ib + CNT_W'(1);
                    end else begin
                        n_ia = r_ia + CNT_W'(1);
                    end
                    if (w_is_last) begin
                        n_state    = ST_IDLE;
                        n_cnt_a    = '0;
                        n_cnt_b    = '0;
                        n_ia       = '0;
                        n_ib       = '0;
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_merged_value <= n_merged_value;
        r_from_b       <= n_from_b;
        r_last         <= n_last;
        r_dropped      <= n_dropped;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_merged_value;
    assign o_from_list_b  = r_from_b;
    assign o_last         = r_last;
    assign o_dropped      = r_dropped;

    // checks
    `SLM_ASSERT_ALWAYS(a_cnt_range, (r_cnt_a <= CNT_W'(LIST_DEPTH)) && (r_cnt_b <= CNT_W'(LIST_DEPTH)), "count beyond store depth")
    `SLM_ASSERT_ALWAYS(a_idx_range, (r_ia <= r_cnt_a) && (r_ib <= r_cnt_b), "read index past count")
    `SLM_ASSERT_ALWAYS(a_idle_idx, (r_state != ST_IDLE) || (r_ia == '0 && r_ib == '0), "read index not rewound in idle")
    `SLM_ASSERT_NEXT(a_empty_merge, w_accept && (i_command == CMD_MERGE) && (r_cnt_a == '0) && (r_cnt_b == '0), (r_state == ST_IDLE) && !r_overflow, "empty merge left idle")
    `SLM_ASSERT_NEXT(a_emit_step, (r_state == ST_MERGE) && w_slot_free, o_out_valid && ((r_ia + r_ib) != $past(r_ia + r_ib) || r_state == ST_IDLE), "merge step did not advance")

endmodule

// File: design/slm_ram.sv
// generic simple dual port ram, one write and one read port
// read data registered; no dependencies
module slm_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, old data on collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/slm_merge_checker.sv
`timescale 1ns / 100ps
// checker for sorted_list_merge_top: watches both channels, predicts every merge
// result from its own copy of the two lists and compares field by field; uses slm_pkg
module slm_merge_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_merged_value,
    input  logic               i_from_list_b,
    input  logic               i_last,
    input  logic               i_dropped,
    output int                 o_fail_count,
    output int                 o_pending
);
    import slm_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               from_b;
        logic               last;
        logic               dropped;
    } t_merged_item;

    // shadow of both lists and the sticky drop flag
    logic signed [31:0] a_words [LIST_DEPTH];
    logic signed [31:0] b_words [LIST_DEPTH];
    int                 a_len;
    int                 b_len;
    logic               drop_flag;

    t_merged_item       merged_queue[$];
    int                 mismatches = 0;

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        mismatches++;
        $display("[%0t] merge mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // walks both lists, smaller head first, list b on a tie
    task automatic merge_lists();
        int           ia;
        int           ib;
        int           total;
        t_merged_item r;
        ia    = 0;
        ib    = 0;
        total = a_len + b_len;
        for (int k = 0; k < total; k++) begin
            if (ia >= a_len)
                r.from_b = 1'b1;
            else if (ib >= b_len)
                r.from_b = 1'b0;
            else
                r.from_b = !(a_words[ia] < b_words[ib]);
            if (r.from_b) begin
                r.value = b_words[ib];
                ib++;
            end else begin
                r.value = a_words[ia];
                ia++;
            end
            r.last    = (k + 1 == total);
            r.dropped = drop_flag;
            merged_queue.push_back(r);
        end
        a_len     = 0;
        b_len     = 0;
        drop_flag = 1'b0;
    endtask

    task automatic take_item(input logic [1:0] cmd, input logic signed [31:0] val);
        case (cmd)
            CMD_PUSH_A: begin
                if (a_len >= LIST_DEPTH) begin
                    drop_flag = 1'b1;
                end else begin
                    a_words[a_len] = val;
                    a_len++;
                end
            end
            CMD_PUSH_B: begin
                if (b_len >= LIST_DEPTH) begin
                    drop_flag = 1'b1;
                end else begin
                    b_words[b_len] = val;
                    b_len++;
                end
            end
            CMD_MERGE: begin
                merge_lists();
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_merged_item want;
        if (merged_queue.size() == 0) begin
            report("result with nothing expected, value", i_merged_value, 0);
        end else begin
            want = merged_queue.pop_front();
            if (i_merged_value !== want.value)
                report("merged_value", i_merged_value, want.value);
            if (i_from_list_b !== want.from_b)
                report("from_list_b", {31'd0, i_from_list_b}, {31'd0, want.from_b});
            if (i_last !== want.last)
                report("last", {31'd0, i_last}, {31'd0, want.last});
            if (i_dropped !== want.dropped)
                report("dropped", {31'd0, i_dropped}, {31'd0, want.dropped});
        end
    endtask

    // input item is taken before the output so a merge lines up ahead of its results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            a_len     = 0;
            b_len     = 0;
            drop_flag = 1'b0;
            merged_queue.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                take_item(i_command, i_value);
            if (i_out_valid && !i_out_stall)
                check_result();
        end
        o_pending    <= merged_queue.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench top for sorted_list_merge_top: clock, reset, list and merge stimulus, verdict
// depends on slm_pkg, sorted_list_merge_top and slm_merge_checker
module tb;
    import slm_pkg::*;

    localparam logic [1:0]         CMD_UNUSED  = 2'd3;
    localparam int                 N_ITEMS     = 460;
    localparam int                 CYCLE_LIMIT = 300000;
    localparam int                 HOLD_CYCLES = 300;
    localparam int                 DRAIN_WAIT  = 20;
    localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX     = 32'sh7FFF_FFFF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [1:0]         command   = 2'd0;
    logic signed [31:0] value     = '0;
    logic               out_stall = 1'b0;

    logic               in_stall;
    logic               out_valid;
    logic signed [31:0] merged_value;
    logic               from_list_b;
    logic               last;
    logic               dropped;

    int                 fail_count;
    int                 pending;
    int                 items_sent = 0;
    int                 cycles     = 0;
    int                 idle_pct   = 35;
    logic               hold_req   = 1'b0;
    logic               hold_done  = 1'b0;
    int                 hold_left  = 0;

    // clock, 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_list_merge_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_value        (value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_merged_value (merged_value),
        .o_from_list_b  (from_list_b),
        .o_last         (last),
        .o_dropped      (dropped)
    );

    slm_merge_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_command      (command),
        .i_value        (value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_merged_value (merged_value),
        .i_from_list_b  (from_list_b),
        .i_last         (last),
        .i_dropped      (dropped),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off once asked for
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // offers one item, with random idle cycles ahead of it, and waits until taken
    task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // next element of an ascending run, saturating at the top of the range, or a random value when unsorted
    function automatic longint step_up(input longint prev, input bit narrow,
                                       input bit unsorted);
        longint nxt;
        if (unsorted)
            return longint'($signed($urandom()));
        nxt = prev + (narrow ? $urandom_range(2) : $urandom_range(1 << 26));
        return (nxt > longint'(VAL_MAX)) ? longint'(VAL_MAX) : nxt;
    endfunction

    // one load of both lists in random interleave, then a merge; or a short burst of noise items
    task automatic run_sequence(input bit force_full);
        int                 kind;
        int                 na;
        int                 nb;
        int                 ia;
        int                 ib;
        bit                 narrow;
        bit                 unsorted;
        bit                 pick_b;
        longint             cur;
        logic signed [31:0] a_vals[$];
        logic signed [31:0] b_vals[$];
        kind = $urandom_range(99);
        // noise: arbitrary commands and values
        if (kind < 8 && !force_full) begin
            repeat ($urandom_range(1, 6))
                send_item(2'($urandom_range(3)), $urandom());
            return;
        end
        narrow   = ($urandom_range(99) < 40);
        unsorted = ($urandom_range(99) < 10);
        na       = $urandom_range(8);
        nb       = $urandom_range(8);
        // long loads, sized near or past the store depth
        if (force_full) begin
            na = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 8);
        end else if (kind < 20) begin
            if ($urandom_range(1))
                na = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 8);
            else
                nb = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 8);
        end
        cur = narrow ? longint'($urandom_range(6)) - 3 : longint'($signed($urandom()));
        for (int k = 0; k < na; k++) begin
            a_vals.push_back(32'(cur));
            cur = step_up(cur, narrow, unsorted);
        end
        cur = narrow ? longint'($urandom_range(6)) - 3 : longint'($signed($urandom()));
        for (int k = 0; k < nb; k++) begin
            b_vals.push_back(32'(cur));
            cur = step_up(cur, narrow, unsorted);
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if ($urandom_range(99) < 4)
                send_item(CMD_UNUSED, $urandom());
            pick_b = (ia >= na) || (ib < nb && $urandom_range(1) == 1);
            if (pick_b) begin
                send_item(CMD_PUSH_B, b_vals[ib]);
                ib++;
            end else begin
                send_item(CMD_PUSH_A, a_vals[ia]);
                ia++;
            end
        end
        send_item(CMD_MERGE, $urandom());
    endtask

    initial begin
        int seq_idx;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty merge and an ignored command
        send_item(CMD_MERGE, VAL_MAX);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF);
        // range extremes with ties on both ends
        send_item(CMD_PUSH_A, VAL_MIN);
        send_item(CMD_PUSH_A, -32'sd1);
        send_item(CMD_PUSH_A, VAL_MAX);
        send_item(CMD_PUSH_B, VAL_MIN);
        send_item(CMD_PUSH_B, 32'sd0);
        send_item(CMD_PUSH_B, VAL_MAX);
        send_item(CMD_MERGE, 32'sd0);
        // unsorted list a
        send_item(CMD_PUSH_A, 32'sd10);
        send_item(CMD_PUSH_A, 32'sd3);
        send_item(CMD_PUSH_B, 32'sd7);
        send_item(CMD_MERGE, VAL_MIN);
        // only list b, then a single element of list a
        send_item(CMD_PUSH_B, 32'sd1);
        send_item(CMD_PUSH_B, 32'sd2);
        send_item(CMD_MERGE, -32'sd1);
        send_item(CMD_PUSH_A, 32'sd42);
        send_item(CMD_MERGE, 32'sd0);

        // random loads and merges; the first one overflows list a
        seq_idx = 0;
        while (items_sent < N_ITEMS) begin
            if (items_sent >= 150)
                hold_req <= 1'b1;
            idle_pct <= (items_sent >= 250 && items_sent < 340) ? 0 : 35;
            run_sequence(seq_idx == 0);
            seq_idx++;
        end
        in_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
